### hdl/kmh_pkg.sv
// shared types and constants for the keyed max-heap accumulator
`timescale 1ns / 1ps
package kmh_pkg;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned GAIN_W  = 32;
  localparam int unsigned TOTAL_W = 48;
  localparam int unsigned SLOT_W  = 8;
  localparam int unsigned COUNT_W = 9;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [GAIN_W-1:0] gain;
  } in_word_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [TOTAL_W-1:0] entry_total;
    logic [KEY_W-1:0]   top_key;
    logic [TOTAL_W-1:0] top_total;
    logic               is_new;
    logic               dropped;
    logic [COUNT_W-1:0] entry_count;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;      // capture input word, clear search index
    logic rd_search;    // read entry at search index
    logic step_search;  // compare read data, advance index
    logic start_upd;    // add gain to found entry / set up new entry
    logic rd_parent;    // read parent of current position
    logic do_swap;      // write parent entry at current position, move up
    logic write_entry;  // write current entry at current position
    logic rd_root;      // read slot 0
    logic load_out;     // form result word
  } kmh_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic match;       // read key equals input key
    logic search_end;  // index has reached fill count
    logic full;
    logic at_root;
    logic parent_less; // entry total >= parent total
  } kmh_sts_t;

endpackage

### hdl/kmh_ram.sv
// generic single-port ram with registered read
`timescale 1ns / 1ps
module kmh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

### hdl/kmh_datapath.sv
// heap datapath: entry memory, search index, sift position and result register
`timescale 1ns / 1ps
module kmh_datapath #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  kmh_pkg::in_word_t  in_word,
  input  kmh_pkg::kmh_cmd_t  cmd,
  output kmh_pkg::kmh_sts_t  sts,
  output kmh_pkg::out_word_t out_word
);
  import kmh_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [KEY_W-1:0]   key_in;
  logic [GAIN_W-1:0]  gain_in;
  logic [CW-1:0]      filled;
  logic [CW-1:0]      idx;
  logic [AW-1:0]      pos;
  logic [KEY_W-1:0]   cur_key;
  logic [TOTAL_W-1:0] cur_total;
  logic               is_new;
  logic               dropped;

  logic               we;
  logic [AW-1:0]      addr;
  logic [KEY_W+TOTAL_W-1:0] wdata;
  logic [KEY_W+TOTAL_W-1:0] rdata;
  logic [KEY_W-1:0]   rd_key;
  logic [TOTAL_W-1:0] rd_total;
  logic [AW-1:0]      parent;
  logic [TOTAL_W:0]   sum;

  // parent entry is written into the current slot during a swap, then
  // the entry itself goes to the parent slot when sifting stops
  logic [KEY_W-1:0]   par_key;
  logic [TOTAL_W-1:0] par_total;

  assign rd_key   = rdata[KEY_W+TOTAL_W-1:TOTAL_W];
  assign rd_total = rdata[TOTAL_W-1:0];
  assign parent   = AW'((pos - AW'(1)) >> 1);
  assign sum      = {1'b0, rd_total} + {{(TOTAL_W-GAIN_W+1){1'b0}}, gain_in};

  kmh_ram #(.WIDTH(KEY_W + TOTAL_W), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (we),
    .addr  (addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  always_comb begin
    we    = 1'b0;
    addr  = idx[AW-1:0];
    wdata = {cur_key, cur_total};
    if (cmd.rd_parent) begin
      addr = parent;
    end else if (cmd.do_swap) begin
      we    = 1'b1;
      addr  = pos;
      wdata = {par_key, par_total};
    end else if (cmd.write_entry) begin
      we   = 1'b1;
      addr = pos;
    end else if (cmd.rd_root) begin
      addr = '0;
    end
  end

  // a match only counts for an index inside the stored entries
  assign sts.match       = (rd_key == key_in) && (idx != filled);
  assign sts.search_end  = (idx == filled);
  assign sts.full        = (filled == CW'(CAPACITY));
  assign sts.at_root     = (pos == '0);
  assign sts.parent_less = (cur_total >= rd_total);

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
    end else if (cmd.start_upd && !sts.match && !sts.full) begin
      filled <= filled + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      key_in  <= in_word.key;
      gain_in <= in_word.gain;
      idx     <= '0;
      is_new  <= 1'b0;
      dropped <= 1'b0;
    end
    if (cmd.step_search && !sts.match) begin
      idx <= idx + CW'(1);
    end
    if (cmd.start_upd) begin
      cur_key <= key_in;
      if (sts.match) begin
        pos       <= idx[AW-1:0];
        cur_total <= sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
      end else begin
        pos       <= filled[AW-1:0];
        cur_total <= {{(TOTAL_W-GAIN_W){1'b0}}, gain_in};
        is_new    <= !sts.full;
        dropped   <= sts.full;
      end
    end
    if (cmd.rd_parent) begin
      par_key   <= rd_key;
      par_total <= rd_total;
    end
    if (cmd.do_swap) begin
      pos <= parent;
    end
    if (cmd.load_out) begin
      out_word.slot        <= dropped ? '0 : SLOT_W'({{(32-AW){1'b0}}, pos});
      out_word.entry_total <= dropped ? '0 : cur_total;
      out_word.top_key     <= rd_key;
      out_word.top_total   <= rd_total;
      out_word.is_new      <= is_new;
      out_word.dropped     <= dropped;
      out_word.entry_count <= COUNT_W'({{(32-CW){1'b0}}, filled});
    end
  end
endmodule

### hdl/kmh_ctrl.sv
// controller state machine for search, update and sift-up
`timescale 1ns / 1ps
module kmh_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  kmh_pkg::kmh_sts_t sts,
  output kmh_pkg::kmh_cmd_t cmd
);
  import kmh_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CHECK  = 9'b000000010,
    S_READ   = 9'b000000100,
    S_CMP    = 9'b000001000,
    S_UPD    = 9'b000010000,
    S_PREAD  = 9'b000100000,
    S_PCMP   = 9'b001000000,
    S_ROOT   = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    in_ready       = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.search_end) begin
          cmd.start_upd = 1'b1;
          state_next    = sts.full ? S_ROOT : S_PREAD;
        end else begin
          cmd.rd_search = 1'b1;
          state_next    = S_READ;
        end
      end
      S_READ: begin
        state_next = S_CMP;
      end
      S_CMP: begin
        cmd.step_search = 1'b1;
        if (sts.match) begin
          cmd.start_upd = 1'b1;
          state_next    = S_PREAD;
        end else begin
          state_next = S_CHECK;
        end
      end
      S_PREAD: begin
        if (sts.at_root) begin
          cmd.write_entry = 1'b1;
          state_next      = S_ROOT;
        end else begin
          cmd.rd_parent = 1'b1;
          state_next    = S_PCMP;
        end
      end
      S_PCMP: begin
        // parent word arrives now; swap when entry is not below it
        if (sts.parent_less) begin
          cmd.rd_parent = 1'b1;
          state_next    = S_UPD;
        end else begin
          cmd.write_entry = 1'b1;
          state_next      = S_ROOT;
        end
      end
      S_UPD: begin
        cmd.do_swap = 1'b1;
        state_next  = S_PREAD;
      end
      S_ROOT: begin
        cmd.rd_root = 1'b1;
        if (!out_valid) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        cmd.load_out   = 1'b1;
        out_valid_next = 1'b1;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end
endmodule

### hdl/keyed_max_heap_accumulate.sv
// each searched entry passes check, read and compare; each swap passes parent read, parent
// compare and update; one word is taken at a time, the next only back in the idle state
// the single port of the entry memory sets the pace of search and sift
// reset clears the fill count and handshake state; entry memory is not cleared
// the next word is accepted while a result still waits at the output register
`timescale 1ns / 1ps
module keyed_max_heap_accumulate #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  kmh_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output kmh_pkg::out_word_t out_data
);
  import kmh_pkg::*;

  kmh_cmd_t cmd;
  kmh_sts_t sts;

  kmh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  kmh_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_word  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_word (out_data)
  );

`ifndef SYNTH
  a_one_hot_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.is_new && out_data.dropped))
    else $error("word both new and dropped");
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.entry_count != '0)
    else $error("result with empty table");
  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.dropped) |-> (out_data.entry_total == '0))
    else $error("dropped word carries a total");
`endif
endmodule
